/* design/i128_pkg.sv */
// shared constants and types for the 128-bit alu
`default_nettype none
package i128_pkg;
  localparam int WORD_BITS_DEF = 128;
  localparam int HALF_BITS     = 64;
  localparam int OP_BITS       = 4;
  localparam int SH_BITS       = 8;

  localparam logic [OP_BITS-1:0] OP_ADD = 4'd0;
  localparam logic [OP_BITS-1:0] OP_SUB = 4'd1;
  localparam logic [OP_BITS-1:0] OP_MUL = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DIV = 4'd3;
  localparam logic [OP_BITS-1:0] OP_AND = 4'd4;
  localparam logic [OP_BITS-1:0] OP_OR  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_XOR = 4'd6;
  localparam logic [OP_BITS-1:0] OP_NOT = 4'd7;
  localparam logic [OP_BITS-1:0] OP_SHL = 4'd8;
  localparam logic [OP_BITS-1:0] OP_SAR = 4'd9;
  localparam logic [OP_BITS-1:0] OP_ROL = 4'd10;
  localparam logic [OP_BITS-1:0] OP_ROR = 4'd11;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_MUL  = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    logic       neg;
    logic       dz;
  } ctl_t;
endpackage
`default_nettype wire

/* design/i128_pre.sv */
// front stage: operand trim, simple ops, multiply and divide operand setup
`default_nettype none
module i128_pre #(
  parameter int WORD_BITS = i128_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           vld_i,
  input  wire logic [i128_pkg::OP_BITS-1:0]   op_i,
  input  wire logic [2*i128_pkg::HALF_BITS-1:0] a_i,
  input  wire logic [2*i128_pkg::HALF_BITS-1:0] b_i,
  input  wire logic [i128_pkg::SH_BITS-1:0]   sh_i,
  output i128_pkg::ctl_t                      ctl_o,
  output logic [WORD_BITS-1:0]                acc_o,
  output logic [WORD_BITS-1:0]                x_o,
  output logic [WORD_BITS-1:0]                y_o
);
  import i128_pkg::*;

  localparam logic [SH_BITS:0] WB = (SH_BITS+1)'(WORD_BITS);

  logic [WORD_BITS-1:0] a, b, na_v, nb_v, res;
  logic                 sh_ok, sa, sb;
  ctl_t                 ctl_r, ctl_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt;

  always_comb begin
    a       = a_i[WORD_BITS-1:0];
    b       = b_i[WORD_BITS-1:0];
    sa      = a[WORD_BITS-1];
    sb      = b[WORD_BITS-1];
    na_v    = sa ? (~a + 1'b1) : a;
    nb_v    = sb ? (~b + 1'b1) : b;
    sh_ok   = (sh_i != '0) && ({1'b0, sh_i} < WB);
    res     = '0;
    case (op_i)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_AND: res = a & b;
      OP_OR:  res = a | b;
      OP_XOR: res = a ^ b;
      OP_NOT: res = ~a;
      OP_SHL: res = sh_ok ? (a << sh_i) : a;
      OP_SAR: res = sh_ok ? WORD_BITS'($signed(a) >>> sh_i) : a;
      OP_ROL: res = {a[WORD_BITS-2:0], a[WORD_BITS-1]};
      OP_ROR: res = {a[0], a[WORD_BITS-1:1]};
      default: res = '0;
    endcase
    ctl_nxt.vld  = vld_i;
    ctl_nxt.mode = MODE_PASS;
    ctl_nxt.neg  = 1'b0;
    ctl_nxt.dz   = 1'b0;
    acc_nxt      = res;
    x_nxt        = a;
    y_nxt        = b;
    if (op_i == OP_MUL) begin
      ctl_nxt.mode = MODE_MUL;
      acc_nxt      = '0;
    end else if (op_i == OP_DIV) begin
      ctl_nxt.mode = MODE_DIV;
      ctl_nxt.neg  = sa ^ sb;
      ctl_nxt.dz   = (b == '0);
      acc_nxt      = '0;
      x_nxt        = na_v;
      y_nxt        = nb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
endmodule
`default_nettype wire

/* design/i128_cell.sv */
// one cell of the chain: a shift-add multiply step, a restoring divide step, or a pass-through
`default_nettype none
module i128_cell #(
  parameter int WORD_BITS = i128_pkg::WORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  i128_pkg::ctl_t       ctl_i,
  input  wire logic [WORD_BITS-1:0] acc_i,
  input  wire logic [WORD_BITS-1:0] x_i,
  input  wire logic [WORD_BITS-1:0] y_i,
  output i128_pkg::ctl_t       ctl_o,
  output logic [WORD_BITS-1:0] acc_o,
  output logic [WORD_BITS-1:0] x_o,
  output logic [WORD_BITS-1:0] y_o
);
  import i128_pkg::*;

  ctl_t                 ctl_r;
  logic [WORD_BITS-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt, rem_s;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  always_comb begin
    rem_s   = {acc_i[WORD_BITS-2:0], x_i[WORD_BITS-1]};
    diff    = {1'b0, rem_s} - {1'b0, y_i};
    ge      = !diff[WORD_BITS];
    acc_nxt = acc_i;
    x_nxt   = x_i;
    y_nxt   = y_i;
    case (ctl_i.mode)
      MODE_MUL: begin
        acc_nxt = acc_i + (y_i[0] ? x_i : '0);
        x_nxt   = x_i << 1;
        y_nxt   = y_i >> 1;
      end
      MODE_DIV: begin
        acc_nxt = ge ? diff[WORD_BITS-1:0] : rem_s;
        x_nxt   = {x_i[WORD_BITS-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
endmodule
`default_nettype wire

/* design/i128_post.sv */
// result stage: quotient sign fix, zero-divisor handling, output register
`default_nettype none
module i128_post #(
  parameter int WORD_BITS = i128_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  i128_pkg::ctl_t            ctl_i,
  input  wire logic [WORD_BITS-1:0] acc_i,
  input  wire logic [WORD_BITS-1:0] x_i,
  output logic                      vld_o,
  output logic [2*i128_pkg::HALF_BITS-1:0] res_o,
  output logic                      dz_o
);
  import i128_pkg::*;

  logic                 vld_r, dz_r, dz_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;

  always_comb begin
    res_nxt = acc_i;
    dz_nxt  = 1'b0;
    if (ctl_i.mode == MODE_DIV) begin
      dz_nxt  = ctl_i.dz;
      res_nxt = ctl_i.dz ? '0 : (ctl_i.neg ? (~x_i + 1'b1) : x_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = (2*HALF_BITS)'(res_r);
  assign dz_o  = dz_r;
endmodule
`default_nettype wire

/* design/int128_alu.sv */
// top level of the 128-bit alu: front stage, chain of step cells, result stage
// every opcode passes the front stage, every cell and the result stage
// throughput: one item per cycle when unstalled; one multiply or divide step per cell
// the whole pipeline advances together whenever the output register is free or taken
// reset (synchronous, rst_n low) clears all valid flags; data registers are not reset
`default_nettype none
module int128_alu #(
  parameter int WORD_BITS = i128_pkg::WORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [i128_pkg::OP_BITS-1:0]     in_req_type,
  input  wire logic [i128_pkg::HALF_BITS-1:0]   in_a_low,
  input  wire logic [i128_pkg::HALF_BITS-1:0]   in_a_high,
  input  wire logic [i128_pkg::HALF_BITS-1:0]   in_b_low,
  input  wire logic [i128_pkg::HALF_BITS-1:0]   in_b_high,
  input  wire logic [i128_pkg::SH_BITS-1:0]     in_shift_amount,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [i128_pkg::HALF_BITS-1:0]        out_result_low,
  output logic [i128_pkg::HALF_BITS-1:0]        out_result_high,
  output logic                                  out_divide_by_zero
);
  import i128_pkg::*;

  logic                   en;
  ctl_t                   ctl [0:WORD_BITS];
  logic [WORD_BITS-1:0]   acc [0:WORD_BITS];
  logic [WORD_BITS-1:0]   xv  [0:WORD_BITS];
  logic [WORD_BITS-1:0]   yv  [0:WORD_BITS];
  logic [2*HALF_BITS-1:0] res;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  i128_pre #(.WORD_BITS(WORD_BITS)) u_pre (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .op_i  (in_req_type),
    .a_i   ({in_a_high, in_a_low}),
    .b_i   ({in_b_high, in_b_low}),
    .sh_i  (in_shift_amount),
    .ctl_o (ctl[0]),
    .acc_o (acc[0]),
    .x_o   (xv[0]),
    .y_o   (yv[0])
  );

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    i128_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl[i]),
      .acc_i (acc[i]),
      .x_i   (xv[i]),
      .y_i   (yv[i]),
      .ctl_o (ctl[i+1]),
      .acc_o (acc[i+1]),
      .x_o   (xv[i+1]),
      .y_o   (yv[i+1])
    );
  end

  i128_post #(.WORD_BITS(WORD_BITS)) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl[WORD_BITS]),
    .acc_i (acc[WORD_BITS]),
    .x_i   (xv[WORD_BITS]),
    .vld_o (out_valid),
    .res_o (res),
    .dz_o  (out_divide_by_zero)
  );

  assign out_result_low  = res[HALF_BITS-1:0];
  assign out_result_high = res[2*HALF_BITS-1:HALF_BITS];

`ifndef SYNTHESIS
  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (res == '0))
    else $error("zero divisor gave a nonzero result");
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result valid right after reset");
`endif
endmodule
`default_nettype wire

/* test/int128_alu_tb.sv */
// testbench for the 128-bit alu: directed and random items checked against a behavioral predictor
`timescale 1ns / 1ps
module int128_alu_tb;
  import i128_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] in_req_type = '0;
  logic [HALF_BITS-1:0] in_a_low = '0, in_a_high = '0, in_b_low = '0, in_b_high = '0;
  logic [SH_BITS-1:0] in_shift_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HALF_BITS-1:0] out_result_low, out_result_high;
  logic out_divide_by_zero;

  typedef struct packed {
    logic [127:0] value;
    logic         dz;
  } alu_result_t;

  alu_result_t pending_results[$];
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint unsigned n_cycles = 0;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int LATENCY = WORD_BITS_DEF + 2;

  int128_alu i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_a_low(in_a_low), .in_a_high(in_a_high),
    .in_b_low(in_b_low), .in_b_high(in_b_high), .in_shift_amount(in_shift_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_low(out_result_low), .out_result_high(out_result_high),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic alu_result_t alu_predict(logic [3:0] op, logic [127:0] a,
                                              logic [127:0] b, logic [7:0] sh);
    alu_result_t r;
    logic [127:0] n, d, q;
    logic neg_q;
    r.value = '0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          n = a[127] ? -a : a;
          d = b[127] ? -b : b;
          q = n / d;
          neg_q = a[127] ^ b[127];
          r.value = neg_q ? -q : q;
        end
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_NOT: r.value = ~a;
      OP_SHL: r.value = (sh != 0 && sh < 128) ? a << sh : a;
      OP_SAR: r.value = (sh != 0 && sh < 128) ? 128'($signed(a) >>> sh) : a;
      OP_ROL: r.value = {a[126:0], a[127]};
      OP_ROR: r.value = {a[0], a[127:1]};
      default: r.value = '0;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [3:0] op, logic [127:0] a, logic [127:0] b, logic [7:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    {in_a_high, in_a_low} <= a;
    {in_b_high, in_b_low} <= b;
    in_shift_amount <= sh;
    pending_results.push_back(alu_predict(op, a, b, sh));
    n_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    alu_result_t exp_r;
    n_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_low !== exp_r.value[63:0]) begin
          $error("result_low expected %h got %h", exp_r.value[63:0], out_result_low);
          n_errors++;
        end
        if (out_result_high !== exp_r.value[127:64]) begin
          $error("result_high expected %h got %h", exp_r.value[127:64], out_result_high);
          n_errors++;
        end
        if (out_divide_by_zero !== exp_r.dz) begin
          $error("divide_by_zero expected %b got %b", exp_r.dz, out_divide_by_zero);
          n_errors++;
        end
      end
    end
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [127:0] rand_word();
    logic [127:0] w;
    w = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = {1'b1, 127'b0};
      3: w = {1'b0, {127{1'b1}}};
      4: w = 128'($urandom_range(9));
      5: w = -128'($urandom_range(9));
      6: w = w >> $urandom_range(127);
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [127:0] mn, mx;
    mn = {1'b1, 127'b0};
    mx = ~mn;
    send_item(OP_ADD, mx, 128'd1, 8'd0);
    send_item(OP_SUB, mn, 128'd1, 8'd0);
    send_item(OP_MUL, '1, '1, 8'd0);
    send_item(OP_MUL, mx, mx, 8'd0);
    send_item(OP_DIV, 128'd7, '0, 8'd0);
    send_item(OP_DIV, mn, '1, 8'd0);
    send_item(OP_DIV, -128'd7, 128'd2, 8'd0);
    send_item(OP_DIV, 128'd7, -128'd2, 8'd0);
    send_item(OP_AND, '1, mx, 8'd0);
    send_item(OP_OR, mn, 128'd5, 8'd0);
    send_item(OP_XOR, '1, mn, 8'd0);
    send_item(OP_NOT, mn, '1, 8'd0);
    send_item(OP_SHL, '1, '0, 8'd0);
    send_item(OP_SHL, '1, '0, 8'd127);
    send_item(OP_SHL, '1, '0, 8'd128);
    send_item(OP_SAR, mn, '0, 8'd255);
    send_item(OP_SAR, mn, '0, 8'd127);
    send_item(OP_SAR, mx, '0, 8'd64);
    send_item(OP_ROL, mn, '0, 8'd9);
    send_item(OP_ROR, 128'd1, '0, 8'd9);
    send_item(4'd12, '1, '1, 8'd1);
    send_item(4'd15, '1, '1, 8'd1);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_item(4'($urandom_range(15)), rand_word(), rand_word(), 8'($urandom));
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    test_random_phase(0, 0, 10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(0, 0, 500);
    test_drain_pause();
    test_random_phase(46, 0, 450);
    test_random_phase(0, 46, 450);
    test_random_phase(18, 18, 450);
    recv_stall_pct = 0;
    wait_drained();
    repeat (LATENCY) @(negedge clk);
    $display("sent %0d items over all opcodes, checked %0d results", n_items, n_results);
    $display("phases: full rate, sender gaps, receiver stalls, mixed");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
